// ===== hw/rtl/ddbc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddbc_pkg: shared types and constants for the drive balance controller
// Register map, datapath widths and the bit-serial multiplier interface.
// ----------------------------------------------------------------------------
package ddbc_pkg;

	localparam int DataW = 32;
	localparam int NumRegs = 8;
	localparam int AddrW = 5;

	localparam logic [2:0] REG_INV_RADIUS = 3'd0;
	localparam logic [2:0] REG_HALF_TRACK = 3'd1;
	localparam logic [2:0] REG_MAX_SPEED = 3'd2;
	localparam logic [2:0] REG_INC_GAIN = 3'd3;
	localparam logic [2:0] REG_SPD_PGAIN = 3'd4;
	localparam logic [2:0] REG_SPD_IGAIN = 3'd5;
	localparam logic [2:0] REG_LEG_MIN = 3'd6;
	localparam logic [2:0] REG_LEG_MAX = 3'd7;

	localparam logic signed [DataW-1:0] S32Max = 32'sh7fffffff;
	localparam logic signed [DataW-1:0] S32Min = 32'sh80000000;

	// Multiplier request from the sequencer.
	typedef struct packed {
		logic start;
		logic signed [DataW-1:0] a;
		logic signed [DataW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic signed [DataW-1:0] q;
	} mul_rsp_t;

	function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] v);
		logic signed [DataW-1:0] r;
		r = v[DataW-1:0];
		if (v[DataW] != v[DataW-1]) r = v[DataW] ? S32Min : S32Max;
		return r;
	endfunction

	function automatic logic signed [DataW-1:0] add_sat(input logic signed [DataW-1:0] a,
			input logic signed [DataW-1:0] b);
		return sat33({a[DataW-1], a} + {b[DataW-1], b});
	endfunction

	function automatic logic signed [DataW-1:0] sub_sat(input logic signed [DataW-1:0] a,
			input logic signed [DataW-1:0] b);
		return sat33({a[DataW-1], a} - {b[DataW-1], b});
	endfunction

endpackage

// ===== hw/rtl/ddbc_qmul.sv =====
// ----------------------------------------------------------------------------
// ddbc_qmul: bit-serial Q16.16 multiplier
// Shift-and-add over the 32 multiplier bits, then floor by 2^16 and saturate to 32 bits.
// ----------------------------------------------------------------------------
module ddbc_qmul
	import ddbc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic signed [2*DataW-1:0] acc_q;
	logic signed [2*DataW-1:0] mcand_q;
	logic [DataW-1:0] mplier_q;
	logic        done_q;
	logic signed [2*DataW-1:0] addend;
	logic signed [2*DataW-1:0] acc_next;
	logic signed [2*DataW-17:0] shifted;

	// The top multiplier bit carries negative weight.
	always_comb begin
		addend = mplier_q[0] ? mcand_q : '0;
		if (cnt_q == 5'd31) addend = -addend;
		acc_next = acc_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcand_q <= {{DataW{req.a[DataW-1]}}, req.a};
			mplier_q <= req.b;
		end else if (busy_q) begin
			acc_q <= acc_next;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	// Arithmetic shift gives floor; saturate the 48-bit quotient.
	assign shifted = acc_q[2*DataW-1:16];
	always_comb begin
		rsp.done = done_q;
		rsp.q = shifted[DataW-1:0];
		if (shifted > 48'sh00007fffffff) rsp.q = S32Max;
		else if (shifted < -48'sh000080000000) rsp.q = S32Min;
	end

endmodule

// ===== hw/rtl/differential_drive_balance_controller.sv =====
// ----------------------------------------------------------------------------
// differential_drive_balance_controller: wheel and leg control per tick
// Each multiply runs start, shift-add steps and done; 6 multiplies in balance
// mode plus a leg state and an output state, 3 multiplies in ground mode. One
// tick at a time; the next input beat is taken in the cycle after the result is
// registered, even while the result waits. The single bit-serial multiplier is
// shared by all multiplies.
// Reset clears the registers to defaults, the integral and mode history.
// ----------------------------------------------------------------------------
module differential_drive_balance_controller
	import ddbc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] lin_vel_target,
	input  logic signed [31:0] ang_vel_target,
	input  logic signed [31:0] incline_target,
	input  logic signed [31:0] incline_measured,
	input  logic signed [31:0] speed_measured,
	input  logic signed [31:0] leg_target_front,
	input  logic signed [31:0] leg_target_back,
	input  logic [3:0] contact_bits,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] front_left_speed,
	output logic signed [31:0] front_right_speed,
	output logic signed [31:0] back_left_speed,
	output logic signed [31:0] back_right_speed,
	output logic signed [31:0] front_leg_cmd,
	output logic signed [31:0] back_leg_cmd,
	output logic balancing
);

	// Sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FWD = 4'd1;  // fwd = err_inc * gain
	localparam logic [3:0] ST_TURN = 4'd2;  // turn = w * half_track
	localparam logic [3:0] ST_LEFT = 4'd3;
	localparam logic [3:0] ST_RIGHT = 4'd4;
	localparam logic [3:0] ST_PTERM = 4'd5;
	localparam logic [3:0] ST_ITERM = 4'd6;
	localparam logic [3:0] ST_LEGS = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;

	// Configuration registers
	logic [30:0] inv_radius_q, half_track_q, max_speed_q;
	logic signed [31:0] inc_gain_q, pgain_q, igain_q, leg_min_q, leg_max_q;
	logic [2:0] reg_idx;
	logic cfg_wr;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_radius_q <= 31'd65536;
			half_track_q <= 31'd65536;
			max_speed_q <= 31'd655360;
			inc_gain_q <= '0;
			pgain_q <= '0;
			igain_q <= '0;
			leg_min_q <= -32'sd205887;
			leg_max_q <= 32'sd205887;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INV_RADIUS: inv_radius_q <= pwdata[30:0];
				REG_HALF_TRACK: half_track_q <= pwdata[30:0];
				REG_MAX_SPEED: max_speed_q <= pwdata[30:0];
				REG_INC_GAIN: inc_gain_q <= pwdata;
				REG_SPD_PGAIN: pgain_q <= pwdata;
				REG_SPD_IGAIN: igain_q <= pwdata;
				REG_LEG_MIN: leg_min_q <= pwdata;
				REG_LEG_MAX: leg_max_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INV_RADIUS: prdata = {1'b0, inv_radius_q};
			REG_HALF_TRACK: prdata = {1'b0, half_track_q};
			REG_MAX_SPEED: prdata = {1'b0, max_speed_q};
			REG_INC_GAIN: prdata = inc_gain_q;
			REG_SPD_PGAIN: prdata = pgain_q;
			REG_SPD_IGAIN: prdata = igain_q;
			REG_LEG_MIN: prdata = leg_min_q;
			REG_LEG_MAX: prdata = leg_max_q;
			default: prdata = '0;
		endcase
	end

	// Working registers for one tick
	logic [3:0] state_q;
	logic signed [31:0] ang_q, err_inc_q, err_spd_q, legf_q, legb_q;
	logic signed [31:0] vel_q, turn_q, left_q, right_q, pterm_q, bias_q;
	logic [3:0] contact_q;
	logic bal_q;
	logic signed [31:0] integ_q;
	logic last_bal_q;
	logic pend_q;      // multiply issued, waiting for done

	// Output register
	logic out_valid_q;
	logic signed [31:0] fl_q, fr_q, bl_q, br_q, fleg_q, bleg_q;
	logic bal_out_q;
	logic out_load;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	ddbc_qmul u_qmul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.rsp(mrsp)
	);

	logic in_bal;
	assign in_bal = (contact_bits == 4'd1) || (contact_bits == 4'd2);
	assign in_ready = (state_q == ST_IDLE);

	// Load the result register once the previous beat has left
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Multiplier operands for the current state
	logic signed [31:0] vmax;
	always_comb begin
		mreq.start = (state_q != ST_IDLE) && (state_q != ST_LEGS) && (state_q != ST_OUT)
			&& !pend_q;
		mreq.a = '0;
		mreq.b = '0;
		case (state_q)
			ST_FWD: begin mreq.a = err_inc_q; mreq.b = inc_gain_q; end
			ST_TURN: begin mreq.a = ang_q; mreq.b = {1'b0, half_track_q}; end
			ST_LEFT: begin mreq.a = sub_sat(vel_q, turn_q); mreq.b = {1'b0, inv_radius_q}; end
			ST_RIGHT: begin mreq.a = add_sat(vel_q, turn_q); mreq.b = {1'b0, inv_radius_q}; end
			ST_PTERM: begin mreq.a = err_spd_q; mreq.b = pgain_q; end
			ST_ITERM: begin mreq.a = integ_q; mreq.b = igain_q; end
			default: ;
		endcase
		vmax = {1'b0, max_speed_q};
	end

	function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		logic signed [31:0] r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	logic signed [31:0] legf_bias, legb_bias;
	assign legf_bias = (bal_q && contact_q[0]) ? sub_sat(legf_q, bias_q) : legf_q;
	assign legb_bias = (bal_q && contact_q[1]) ? sub_sat(legb_q, bias_q) : legb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
			integ_q <= '0;
			last_bal_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (mreq.start) pend_q <= 1'b1;
			if (mrsp.done) pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						// Clear the integral on a mode change; in balance mode, then accumulate.
						if (in_bal) begin
							integ_q <= add_sat((in_bal != last_bal_q) ? '0 : integ_q,
								sub_sat(lin_vel_target, speed_measured));
						end else if (in_bal != last_bal_q) begin
							integ_q <= '0;
						end
						last_bal_q <= in_bal;
						state_q <= in_bal ? ST_FWD : ST_TURN;
					end
				end
				ST_FWD: if (mrsp.done) state_q <= ST_TURN;
				ST_TURN: if (mrsp.done) state_q <= ST_LEFT;
				ST_LEFT: if (mrsp.done) state_q <= ST_RIGHT;
				ST_RIGHT: if (mrsp.done) state_q <= bal_q ? ST_PTERM : ST_LEGS;
				ST_PTERM: if (mrsp.done) state_q <= ST_ITERM;
				ST_ITERM: if (mrsp.done) state_q <= ST_LEGS;
				ST_LEGS: state_q <= ST_OUT;
				ST_OUT: begin
					// Hold until the previous result beat has left.
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload: capture operands and products
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			vel_q <= lin_vel_target;
			ang_q <= ang_vel_target;
			err_inc_q <= sub_sat(incline_target, incline_measured);
			err_spd_q <= sub_sat(lin_vel_target, speed_measured);
			legf_q <= leg_target_front;
			legb_q <= leg_target_back;
			contact_q <= contact_bits;
			bal_q <= in_bal;
		end
		if (mrsp.done) begin
			case (state_q)
				ST_FWD: vel_q <= mrsp.q;
				ST_TURN: turn_q <= mrsp.q;
				ST_LEFT: left_q <= clamp(mrsp.q, -vmax, vmax);
				ST_RIGHT: right_q <= clamp(mrsp.q, -vmax, vmax);
				ST_PTERM: pterm_q <= mrsp.q;
				ST_ITERM: bias_q <= add_sat(pterm_q, mrsp.q);
				default: ;
			endcase
		end
		if (state_q == ST_LEGS) begin
			legf_q <= clamp(legf_bias, leg_min_q, leg_max_q);
			legb_q <= clamp(legb_bias, leg_min_q, leg_max_q);
		end
		if (out_load) begin
			fl_q <= contact_q[0] ? left_q : '0;
			fr_q <= contact_q[0] ? right_q : '0;
			bl_q <= contact_q[1] ? left_q : '0;
			br_q <= contact_q[1] ? right_q : '0;
			fleg_q <= legf_q;
			bleg_q <= legb_q;
			bal_out_q <= bal_q;
		end
	end

	assign out_valid = out_valid_q;
	assign front_left_speed = fl_q;
	assign front_right_speed = fr_q;
	assign back_left_speed = bl_q;
	assign back_right_speed = br_q;
	assign front_leg_cmd = fleg_q;
	assign back_leg_cmd = bleg_q;
	assign balancing = bal_out_q;

	// Drop a stalled result never: it must hold while waiting.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(front_leg_cmd))
		else $error("result beat changed while stalled");
	a_mul_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> state_q != ST_IDLE)
		else $error("multiplier finished with sequencer idle");
	a_mode_track: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> last_bal_q == bal_q)
		else $error("mode history not updated");

endmodule
